@@ src/numeric_literal_classifier_assert.svh @@
// Assertion macros used by the checker file of the literal classifier.
`ifndef NUMERIC_LITERAL_CLASSIFIER_ASSERT_SVH
`define NUMERIC_LITERAL_CLASSIFIER_ASSERT_SVH

// Checked on every rising edge outside reset.
`define NLC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define NLC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/nlc_pkg.sv @@
// Shared types and constants of the numeric literal classifier.
package nlc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 3;
    localparam int unsigned CNT_W    = 2;
    localparam int unsigned ALIVE_W  = 3;
    localparam int unsigned FLAGS_W  = 4;
    localparam int unsigned M_DATA_W = 8;

    localparam logic [BYTE_W-1:0] PRINT_LO = 8'd32;
    localparam logic [BYTE_W-1:0] PRINT_HI = 8'd126;

    localparam logic [POS_W-1:0] POS_MAX = 3'd7;
    localparam logic [CNT_W-1:0] CNT_MAX = 2'd3;

    // Bit positions in the word candidate mask.
    localparam int unsigned W_NAN  = 0;
    localparam int unsigned W_INF  = 1;
    localparam int unsigned W_SINF = 2;

    // Result flags of one token, highest bit first; int_ok is bit 0 on the output bus.
    typedef struct packed {
        logic double_ok;
        logic float_ok;
        logic char_ok;
        logic int_ok;
    } nlc_flags_t;

    // One finished token as handed from the scanner to the output stage.
    typedef struct packed {
        logic       valid;
        nlc_flags_t flags;
    } nlc_result_t;

    function automatic logic [BYTE_W-1:0] nan_char(input logic [1:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            2'd0:    c = "n";
            2'd1:    c = "a";
            2'd2:    c = "n";
            default: c = "f";
        endcase
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] inf_char(input logic [1:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            2'd0:    c = "i";
            2'd1:    c = "n";
            default: c = "f";
        endcase
        return c;
    endfunction

endpackage

@@ src/nlc_scan.sv @@
// Per-byte recogniser state and the token result decision.
module nlc_scan
    import nlc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [BYTE_W-1:0] byte_in,
    input  logic              is_last,
    output nlc_result_t       result
);

    typedef enum logic [6:0] {
        PH_START = 7'b0000001,
        PH_SIGN  = 7'b0000010,
        PH_INT   = 7'b0000100,
        PH_DOT   = 7'b0001000,
        PH_FRAC  = 7'b0010000,
        PH_FSEEN = 7'b0100000,
        PH_DEAD  = 7'b1000000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [ALIVE_W-1:0] alive_reg, alive_next, alive_now;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               first_print_reg, first_print_next, first_print_now;
    logic               digit, sign, printable;
    logic [1:0]         pos_low, pos_prev;
    logic               word_float, word_double;

    assign digit     = (byte_in >= "0") && (byte_in <= "9");
    assign sign      = (byte_in == "+") || (byte_in == "-");
    assign printable = (byte_in >= PRINT_LO) && (byte_in <= PRINT_HI);
    assign pos_low   = pos_reg[1:0];
    assign pos_prev  = pos_low - 2'd1;

    always_comb
    begin
        unique case (phase_reg)
            PH_START: phase_next = sign ? PH_SIGN : (digit ? PH_INT : PH_DEAD);
            PH_SIGN:  phase_next = digit ? PH_INT : PH_DEAD;
            PH_INT:   phase_next = digit ? PH_INT : ((byte_in == ".") ? PH_DOT : PH_DEAD);
            PH_DOT:   phase_next = digit ? PH_FRAC : PH_DEAD;
            PH_FRAC:  phase_next = digit ? PH_FRAC : ((byte_in == "f") ? PH_FSEEN : PH_DEAD);
            default:  phase_next = PH_DEAD;
        endcase
    end

    always_comb
    begin
        alive_now = alive_reg;
        if (pos_reg[2] || (byte_in != nan_char(pos_low)))
        begin
            alive_now[W_NAN] = 1'b0;
        end
        if (pos_reg[2] || (byte_in != inf_char(pos_low)))
        begin
            alive_now[W_INF] = 1'b0;
        end
        if (pos_reg == '0)
        begin
            if (!sign)
            begin
                alive_now[W_SINF] = 1'b0;
            end
        end
        else if ((pos_reg > 3'd4) || (byte_in != inf_char(pos_prev)))
        begin
            alive_now[W_SINF] = 1'b0;
        end
    end

    // The token length so far is one more than the position.
    assign word_float  = ((alive_now[W_NAN] || alive_now[W_INF]) && (pos_reg == 3'd3))
                       || (alive_now[W_SINF] && (pos_reg == 3'd4));
    assign word_double = ((alive_now[W_NAN] || alive_now[W_INF]) && (pos_reg == 3'd2))
                       || (alive_now[W_SINF] && (pos_reg == 3'd3));

    assign first_print_now = (count_reg == '0) ? printable : first_print_reg;

    always_comb
    begin
        result.valid           = take && is_last;
        result.flags.int_ok    = (phase_next == PH_INT);
        result.flags.char_ok   = (count_reg == '0) && first_print_now;
        result.flags.float_ok  = (phase_next == PH_FSEEN) || word_float;
        result.flags.double_ok = (phase_next == PH_FRAC) || word_double;
    end

    always_comb
    begin
        pos_next         = (pos_reg < POS_MAX) ? pos_reg + 3'd1 : pos_reg;
        count_next       = (count_reg < CNT_MAX) ? count_reg + 2'd1 : count_reg;
        alive_next       = alive_now;
        first_print_next = first_print_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_START;
            pos_reg         <= '0;
            alive_reg       <= '1;
            count_reg       <= '0;
            first_print_reg <= 1'b0;
        end
        else if (take)
        begin
            if (is_last)
            begin
                phase_reg       <= PH_START;
                pos_reg         <= '0;
                alive_reg       <= '1;
                count_reg       <= '0;
                first_print_reg <= 1'b0;
            end
            else
            begin
                phase_reg       <= phase_next;
                pos_reg         <= pos_next;
                alive_reg       <= alive_next;
                count_reg       <= count_next;
                first_print_reg <= first_print_next;
            end
        end
    end

endmodule

@@ src/nlc_out.sv @@
// Result register on the master side of the classifier.
module nlc_out
    import nlc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  nlc_result_t         result,
    output logic                space,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic       valid_reg;
    nlc_flags_t flags_reg;

    assign space    = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_DATA_W-FLAGS_W){1'b0}}, flags_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (result.valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            flags_reg <= result.flags;
        end
    end

endmodule

@@ src/numeric_literal_classifier.sv @@
// Top level of the numeric literal classifier.
//
//  channel  direction  tdata                          tuser  tlast
//  s        in         [7:0] byte_in                  -      is_last
//  m        out        [3:0] int, char, float, double -      -
//
// One byte is taken per cycle while s_tready is high; a token's result is
// registered and appears in the cycle after its last byte is taken.
// Reset clears the recogniser and the valid bit of the result register, and
// the next byte starts a new token. Bytes are held off only while a result
// waits on a stalled master side.
module numeric_literal_classifier
    import nlc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [BYTE_W-1:0]   s_tdata,   // byte_in
    input  logic                s_tlast,   // is_last
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // int_ok, char_ok, float_ok, double_ok, zeros
);

    nlc_result_t result;
    logic        space;

    assign s_tready = space;

    nlc_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (s_tvalid && s_tready),
        .byte_in (s_tdata),
        .is_last (s_tlast),
        .result  (result)
    );

    nlc_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .result   (result),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ src/nlc_checker.sv @@
// Port-level checks of the numeric literal classifier and their binding.
`include "numeric_literal_classifier_assert.svh"

module nlc_checker
    import nlc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                s_tlast,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    logic s_take;
    assign s_take = s_tvalid && s_tready;

    `NLC_ASSERT(a_held, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped while stalled")
    `NLC_ASSERT(a_last_gives, s_take && s_tlast |=> m_tvalid, "last byte gave no result")
    `NLC_ASSERT(a_mid_quiet, s_take && !s_tlast && !m_tvalid |=> !m_tvalid, "result without last byte")
    `NLC_ASSERT(a_int_excl, m_tvalid |-> !(m_tdata[0] && (m_tdata[2] || m_tdata[3])), "int and fraction flags together")
    `NLC_ASSERT_ALWAYS(a_pad, m_tvalid |-> (m_tdata[7:4] == 4'd0), "padding bits not zero")

endmodule

bind numeric_literal_classifier nlc_checker u_nlc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ bench/numeric_literal_classifier_tb.sv @@
// Self-checking testbench that streams tokens through the literal classifier and checks its flags.
module numeric_literal_classifier_tb;
    import nlc_pkg::*;

    typedef enum logic [2:0] {
        LIT_START,
        LIT_SIGN,
        LIT_INT,
        LIT_DOT,
        LIT_FRAC,
        LIT_FSEEN,
        LIT_DEAD
    } lit_phase_t;

    typedef struct packed {
        logic              is_last;
        logic [BYTE_W-1:0] ch;
    } tok_byte_t;

    localparam logic [31:0] NAN_WORD = "nanf";
    localparam logic [31:0] INF_WORD = "inff";
    localparam int HOLD_CYCLES = 300;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    tok_byte_t     byte_q[$];
    nlc_flags_t    flag_q[$];
    logic [7:0]    tok_buf[$];
    string         lit_chars = "+-.0123456789fnaix";

    lit_phase_t          lit_phase;
    logic [POS_W-1:0]    word_pos;
    logic [ALIVE_W-1:0]  word_live;
    logic [CNT_W-1:0]    tok_count;
    logic                first_print;

    int   errors = 0;
    int   bytes_queued = 0;
    int   send_idle = 0;
    int   recv_idle = 0;
    int   hold_asks = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    logic req_taken = 1'b0;
    nlc_flags_t want;

    numeric_literal_classifier DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic lit_phase_t next_lit(input lit_phase_t ph, input logic [7:0] c);
        logic       digit;
        lit_phase_t nx;
        digit = (c >= "0") && (c <= "9");
        case (ph)
            LIT_START: nx = (c == "+" || c == "-") ? LIT_SIGN : (digit ? LIT_INT : LIT_DEAD);
            LIT_SIGN:  nx = digit ? LIT_INT : LIT_DEAD;
            LIT_INT:   nx = digit ? LIT_INT : ((c == ".") ? LIT_DOT : LIT_DEAD);
            LIT_DOT:   nx = digit ? LIT_FRAC : LIT_DEAD;
            LIT_FRAC:  nx = digit ? LIT_FRAC : ((c == "f") ? LIT_FSEEN : LIT_DEAD);
            default:   nx = LIT_DEAD;
        endcase
        return nx;
    endfunction

    function automatic logic [ALIVE_W-1:0] next_live(input logic [ALIVE_W-1:0] live,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic [7:0] c);
        logic [ALIVE_W-1:0] nx;
        logic [1:0]         sidx;
        nx = live;
        sidx = pos[1:0] - 2'd1;
        if (pos >= 3'd4 || c != NAN_WORD[31 - 8 * pos[1:0] -: 8])
            nx[W_NAN] = 1'b0;
        if (pos >= 3'd4 || c != INF_WORD[31 - 8 * pos[1:0] -: 8])
            nx[W_INF] = 1'b0;
        if (pos == 3'd0)
        begin
            if (c != "+" && c != "-")
                nx[W_SINF] = 1'b0;
        end
        else if (pos >= 3'd5 || c != INF_WORD[31 - 8 * sidx -: 8])
        begin
            nx[W_SINF] = 1'b0;
        end
        return nx;
    endfunction

    task clear_scan();
        lit_phase = LIT_START;
        word_pos = '0;
        word_live = '1;
        tok_count = '0;
        first_print = 1'b0;
    endtask

    // Advances the scanner by one accepted byte and queues the flags a final byte produces.
    task scan_byte(input tok_byte_t b);
        lit_phase_t         ph;
        logic [ALIVE_W-1:0] live;
        logic [3:0]         len;
        logic               wf;
        logic               wd;
        nlc_flags_t         f;
        ph = next_lit(lit_phase, b.ch);
        live = next_live(word_live, word_pos, b.ch);
        len = {1'b0, word_pos} + 4'd1;
        if (tok_count == '0)
            first_print = (b.ch >= PRINT_LO) && (b.ch <= PRINT_HI);
        if (!b.is_last)
        begin
            lit_phase = ph;
            word_live = live;
            if (word_pos != POS_MAX)
                word_pos = word_pos + 1'b1;
            if (tok_count != CNT_MAX)
                tok_count = tok_count + 1'b1;
        end
        else
        begin
            wf = ((live[W_NAN] || live[W_INF]) && len == 4'd4) || (live[W_SINF] && len == 4'd5);
            wd = ((live[W_NAN] || live[W_INF]) && len == 4'd3) || (live[W_SINF] && len == 4'd4);
            f.int_ok = (ph == LIT_INT);
            f.char_ok = (tok_count == '0) && first_print;
            f.float_ok = (ph == LIT_FSEEN) || wf;
            f.double_ok = (ph == LIT_FRAC) || wd;
            flag_q.push_back(f);
            clear_scan();
        end
    endtask

    task queue_token();
        tok_byte_t item;
        foreach (tok_buf[i])
        begin
            item.ch = tok_buf[i];
            item.is_last = (i == tok_buf.size() - 1);
            byte_q.push_back(item);
        end
        bytes_queued += tok_buf.size();
    endtask

    task push_text(input string s);
        tok_buf.delete();
        for (int i = 0; i < s.len(); i++)
            tok_buf.push_back(s[i]);
        queue_token();
    endtask

    task push_raw(input logic [7:0] b);
        tok_buf.delete();
        tok_buf.push_back(b);
        queue_token();
    endtask

    task add_digits();
        int n;
        if ($urandom_range(0, 15) == 0)
            n = 0;
        else if ($urandom_range(0, 7) == 0)
            n = $urandom_range(4, 9);
        else
            n = $urandom_range(1, 3);
        repeat (n)
            tok_buf.push_back(8'("0" + $urandom_range(0, 9)));
    endtask

    // Mostly well-formed literals and words, some of them damaged, and some plain noise.
    task make_token();
        int    kind;
        int    sgn;
        string w;
        kind = $urandom_range(0, 9);
        tok_buf.delete();
        if (kind <= 5)
        begin
            sgn = $urandom_range(0, 2);
            if (sgn == 1)
                tok_buf.push_back("+");
            else if (sgn == 2)
                tok_buf.push_back("-");
            add_digits();
            if (kind >= 2)
            begin
                tok_buf.push_back(".");
                add_digits();
            end
            if (kind >= 4)
                tok_buf.push_back("f");
        end
        else if (kind == 6)
        begin
            case ($urandom_range(0, 7))
                0:       w = "nan";
                1:       w = "nanf";
                2:       w = "inf";
                3:       w = "inff";
                4:       w = "+inf";
                5:       w = "-inf";
                6:       w = "+inff";
                default: w = "-inff";
            endcase
            for (int i = 0; i < w.len(); i++)
                tok_buf.push_back(w[i]);
        end
        else if (kind == 7)
        begin
            tok_buf.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind == 8)
        begin
            repeat ($urandom_range(1, 10))
                tok_buf.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                tok_buf.push_back(lit_chars[$urandom_range(0, lit_chars.len() - 1)]);
        end
        if (tok_buf.size() == 0)
            tok_buf.push_back("0");
        if (kind <= 6 && $urandom_range(0, 5) == 0)
            tok_buf[$urandom_range(0, tok_buf.size() - 1)] =
                lit_chars[$urandom_range(0, lit_chars.len() - 1)];
        queue_token();
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || req_taken)
        begin
            if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= byte_q[0].ch;
                s_tlast <= byte_q[0].is_last;
                void'(byte_q.pop_front());
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_taken = 1'b0;
        end
        else
        begin
            req_taken = s_tvalid && s_tready;
            if (req_taken)
                scan_byte({s_tlast, s_tdata});
            if (m_tvalid && m_tready)
            begin
                if (flag_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("Unexpected request %h at %0t.", m_tdata, $time);
                end
                else
                begin
                    want = flag_q.pop_front();
                    if (m_tdata != {{(M_DATA_W - FLAGS_W){1'b0}}, want})
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("Mismatch at %0t: expected int %b char %b float %b double %b,",
                                     $time, want.int_ok, want.char_ok, want.float_ok,
                                     want.double_ok,
                                     " got int %b char %b float %b double %b pad %h.",
                                     m_tdata[0], m_tdata[1], m_tdata[2],
                                     m_tdata[3], m_tdata[M_DATA_W-1:FLAGS_W]);
                    end
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int target;
        clear_scan();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 36 : ((ph == 1) ? 60 : 0);
            recv_idle = (ph == 0) ? 60 : ((ph == 1) ? 36 : 0);
            if (ph == 0)
            begin
                push_text("0");
                push_text("-7");
                push_text("+42");
                push_text("+");
                push_text("3.");
                push_text("-3.5");
                push_text("+0.25f");
                push_text("1.f");
                push_text(".5");
                push_text("nan");
                push_text("nanf");
                push_text("inf");
                push_text("inff");
                push_text("+inf");
                push_text("-inf");
                push_text("+inff");
                push_text("-inff");
                push_text("nanff");
                push_text("12345678901");
                push_text("a");
                push_text("~");
                push_text(" ");
                push_raw(8'h1f);
                push_raw(8'h7f);
                push_raw(8'h00);
                push_raw(8'hff);
            end
            target = bytes_queued + 200;
            while (bytes_queued < target)
                make_token();
            // The receiver stops for a long stretch so that results back up into the input.
            if (ph == 2)
                hold_asks = hold_asks + 1;
            while (byte_q.size() != 0 || s_tvalid || flag_q.size() != 0)
                @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (errors == 0 && flag_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/nlc_pkg.sv
src/nlc_scan.sv
src/nlc_out.sv
src/numeric_literal_classifier.sv
src/nlc_checker.sv
bench/numeric_literal_classifier_tb.sv
